### src/stun_rap_pkg.sv
package stun_rap_pkg;

  localparam int unsigned HEADER_BYTES = 20;

  localparam logic [15:0] TYPE_SUCCESS   = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED    = 16'h0001;
  localparam logic [15:0] ATTR_XOR       = 16'h0020;
  localparam logic [15:0] PORT_MASK      = 16'h2112;
  localparam logic [31:0] COOKIE         = 32'h2112A442;
  localparam logic [15:0] MIN_ADDR_LEN   = 16'd8;
  localparam logic [15:0] ATTR_HDR_BYTES = 16'd4;
  localparam logic [15:0] CAPTURE_FIRST  = 16'd1;
  localparam logic [15:0] CAPTURE_LAST   = 16'd7;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_VALUE    = 3'd2,
    PH_PAD      = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    logic        address_kind;
    logic [7:0]  address_family;
    logic [15:0] external_port;
    logic [31:0] external_ip;
  } addr_result_t;

endpackage

### src/stun_rap_if.sv
interface stun_rap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source(output valid, output data_byte, output end_of_datagram, input ready);
  modport sink(input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface stun_rap_out_if;
  logic        valid;
  logic        ready;
  logic        address_kind;
  logic [7:0]  address_family;
  logic [15:0] external_port;
  logic [31:0] external_ip;

  modport source(output valid, output address_kind, output address_family,
                 output external_port, output external_ip, input ready);
  modport sink(input valid, input address_kind, input address_family,
               input external_port, input external_ip, output ready);
endinterface

### src/stun_response_address_parser_unit.sv
// Parses a STUN Binding Success Response arriving one byte per transfer and reports the first
// complete MAPPED-ADDRESS or XOR-MAPPED-ADDRESS it carries (XOR values already unmasked), at
// most one result per datagram. A byte is taken every cycle unless the input stalls as below: it
// is held in an input register, the parser updates its state from it, and the result from the
// byte that completes the address value is loaded into the output register when the parser
// takes that byte, ready for its own transfer. Input stalls only when that completing byte meets
// a result that has not yet been taken. No clearing pass is needed after reset.
module stun_response_address_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  stun_rap_in_if.sink    in_ch,
  stun_rap_out_if.source out_ch
);

  logic                       byte_valid;
  logic [7:0]                 data_byte;
  logic                       last;
  logic                       take;
  logic                       emit;
  logic                       out_free;
  stun_rap_pkg::addr_result_t result;

  stun_rap_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .last       (last)
  );

  stun_rap_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .last       (last),
    .out_free   (out_free),
    .take       (take),
    .emit       (emit),
    .result     (result)
  );

  stun_rap_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit),
    .result   (result),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

### src/stun_rap_in_reg.sv
module stun_rap_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  stun_rap_in_if.sink       in_ch,
  input  logic              take,
  output logic              byte_valid,
  output logic [7:0]        data_byte,
  output logic              last
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  // The register refills in the same cycle that the core consumes its byte.
  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.data_byte;
      last_r <= in_ch.end_of_datagram;
    end
  end

  assign byte_valid = valid_r;
  assign data_byte  = data_r;
  assign last       = last_r;

endmodule

### src/stun_rap_core.sv
module stun_rap_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_valid,
  input  logic [7:0]                 data_byte,
  input  logic                       last,
  input  logic                       out_free,
  output logic                       take,
  output logic                       emit,
  output stun_rap_pkg::addr_result_t result
);

  stun_rap_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  msg_hi_r, msg_hi_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [55:0] cap_r, cap_nxt;
  logic [15:0] cnt_inc;
  logic [15:0] new_len;
  logic [2:0]  pad_len;
  logic        is_addr;
  logic        is_xor;
  logic        emit_cand;

  assign cnt_inc = cnt_r + 16'd1;
  assign new_len = {len_r[15:8], data_byte};
  assign pad_len = 3'd4 - {1'b0, len_r[1:0]};
  assign is_xor  = (type_r == stun_rap_pkg::ATTR_XOR);
  assign is_addr = ((type_r == stun_rap_pkg::ATTR_MAPPED) || is_xor) &&
                   (len_r >= stun_rap_pkg::MIN_ADDR_LEN);

  // A byte that completes an address value needs room in the result register.
  assign emit_cand = (phase_r == stun_rap_pkg::PH_VALUE) && (cnt_inc == len_r) && is_addr;
  assign take      = byte_valid && (!emit_cand || out_free);
  assign emit      = take && emit_cand;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_inc;
    msg_hi_nxt = msg_hi_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    cap_nxt    = cap_r;
    case (phase_r)
      stun_rap_pkg::PH_HEADER: begin
        if (cnt_r == 16'd0) begin
          msg_hi_nxt = data_byte;
        end
        if (cnt_r == 16'd1 && {msg_hi_r, data_byte} != stun_rap_pkg::TYPE_SUCCESS) begin
          phase_nxt = stun_rap_pkg::PH_DONE;
        end else if (cnt_inc >= 16'(stun_rap_pkg::HEADER_BYTES)) begin
          cnt_nxt   = 16'd0;
          phase_nxt = stun_rap_pkg::PH_ATTR_HDR;
        end
      end
      stun_rap_pkg::PH_ATTR_HDR: begin
        case (cnt_r[1:0])
          2'd0:    type_nxt[15:8] = data_byte;
          2'd1:    type_nxt[7:0]  = data_byte;
          2'd2:    len_nxt[15:8]  = data_byte;
          default: len_nxt[7:0]   = data_byte;
        endcase
        if (cnt_inc >= stun_rap_pkg::ATTR_HDR_BYTES) begin
          cnt_nxt = 16'd0;
          cap_nxt = '0;
          // A zero-length value has no padding either.
          if (new_len == 16'd0) begin
            phase_nxt = stun_rap_pkg::PH_ATTR_HDR;
          end else begin
            phase_nxt = stun_rap_pkg::PH_VALUE;
          end
        end
      end
      stun_rap_pkg::PH_VALUE: begin
        if (cnt_r >= stun_rap_pkg::CAPTURE_FIRST && cnt_r <= stun_rap_pkg::CAPTURE_LAST) begin
          cap_nxt = {cap_r[47:0], data_byte};
        end
        if (cnt_inc == len_r) begin
          cnt_nxt = 16'd0;
          if (is_addr) begin
            phase_nxt = stun_rap_pkg::PH_DONE;
          end else if (len_r[1:0] != 2'd0) begin
            phase_nxt = stun_rap_pkg::PH_PAD;
          end else begin
            phase_nxt = stun_rap_pkg::PH_ATTR_HDR;
          end
        end
      end
      stun_rap_pkg::PH_PAD: begin
        if (cnt_inc >= {13'd0, pad_len}) begin
          cnt_nxt   = 16'd0;
          phase_nxt = stun_rap_pkg::PH_ATTR_HDR;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    // The last byte of a datagram returns the parser to the start of a header.
    if (last) begin
      phase_nxt = stun_rap_pkg::PH_HEADER;
      cnt_nxt   = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= stun_rap_pkg::PH_HEADER;
      cnt_r   <= 16'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      msg_hi_r <= msg_hi_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      cap_r    <= cap_nxt;
    end
  end

  assign result.address_kind   = is_xor;
  assign result.address_family = cap_nxt[55:48];
  assign result.external_port  = is_xor ? (cap_nxt[47:32] ^ stun_rap_pkg::PORT_MASK)
                                        : cap_nxt[47:32];
  assign result.external_ip    = is_xor ? (cap_nxt[31:0] ^ stun_rap_pkg::COOKIE)
                                        : cap_nxt[31:0];

  a_emit_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last |=> phase_r == stun_rap_pkg::PH_DONE)
    else $error("parser did not stop after reporting an address");

  a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == stun_rap_pkg::PH_HEADER |-> cnt_r < 16'(stun_rap_pkg::HEADER_BYTES))
    else $error("header byte count ran past the header");

  a_attr_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == stun_rap_pkg::PH_ATTR_HDR |-> cnt_r < stun_rap_pkg::ATTR_HDR_BYTES)
    else $error("attribute header count ran past four bytes");

  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == stun_rap_pkg::PH_PAD |-> cnt_r < 16'd3 && len_r[1:0] != 2'd0)
    else $error("padding state entered without padding to skip");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> phase_r == stun_rap_pkg::PH_HEADER && cnt_r == 16'd0)
    else $error("parser did not restart after the last byte of a datagram");

endmodule

### src/stun_rap_out_reg.sv
module stun_rap_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  stun_rap_pkg::addr_result_t result,
  output logic                       out_free,
  stun_rap_out_if.source             out_ch
);

  logic                       valid_r;
  stun_rap_pkg::addr_result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res_r <= result;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.address_kind   = res_r.address_kind;
  assign out_ch.address_family = res_r.address_family;
  assign out_ch.external_port  = res_r.external_port;
  assign out_ch.external_ip    = res_r.external_ip;

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result offered while the previous one still waits");

endmodule

### tb/stun_response_address_parser_unit_tb.sv
`timescale 1ns / 1ps

module stun_response_address_parser_unit_tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TARGET_BYTES = 1750;
  localparam int unsigned TAIL_CYCLES = 8;

  // Keeps its own copy of the parser state and predicts the address each datagram yields.
  class address_scoreboard;
    stun_rap_pkg::addr_result_t expected_addrs[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned xor_seen;
    stun_rap_pkg::phase_t phase;
    logic [15:0] sect_cnt;
    logic [15:0] msg_type;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [55:0] capture;

    function new();
      errors = 0;
      checked = 0;
      xor_seen = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = stun_rap_pkg::PH_HEADER;
      sect_cnt = '0;
      msg_type = '0;
      attr_type = '0;
      attr_len = '0;
      capture = '0;
    endfunction

    function void skip_value();
      sect_cnt = '0;
      if (attr_len[1:0] != 2'd0) begin
        phase = stun_rap_pkg::PH_PAD;
      end else begin
        phase = stun_rap_pkg::PH_ATTR_HDR;
      end
    endfunction

    function int pending();
      return expected_addrs.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      stun_rap_pkg::addr_result_t res;
      logic [15:0] pad_need;
      case (phase)
        stun_rap_pkg::PH_HEADER: begin
          if (sect_cnt == 16'd0) begin
            msg_type = {b, 8'h00};
          end else if (sect_cnt == 16'd1) begin
            msg_type[7:0] = b;
          end
          sect_cnt = sect_cnt + 16'd1;
          if (sect_cnt == 16'd2 && msg_type != stun_rap_pkg::TYPE_SUCCESS) begin
            phase = stun_rap_pkg::PH_DONE;
          end else if (sect_cnt >= 16'(stun_rap_pkg::HEADER_BYTES)) begin
            sect_cnt = '0;
            phase = stun_rap_pkg::PH_ATTR_HDR;
          end
        end
        stun_rap_pkg::PH_ATTR_HDR: begin
          case (sect_cnt)
            16'd0: attr_type = {b, 8'h00};
            16'd1: attr_type[7:0] = b;
            16'd2: attr_len = {b, 8'h00};
            default: attr_len[7:0] = b;
          endcase
          sect_cnt = sect_cnt + 16'd1;
          if (sect_cnt >= stun_rap_pkg::ATTR_HDR_BYTES) begin
            sect_cnt = '0;
            capture = '0;
            if (attr_len == 16'd0) begin
              skip_value();
            end else begin
              phase = stun_rap_pkg::PH_VALUE;
            end
          end
        end
        stun_rap_pkg::PH_VALUE: begin
          if (sect_cnt >= stun_rap_pkg::CAPTURE_FIRST &&
              sect_cnt <= stun_rap_pkg::CAPTURE_LAST) begin
            capture = {capture[47:0], b};
          end
          sect_cnt = sect_cnt + 16'd1;
          if (sect_cnt == attr_len) begin
            if ((attr_type == stun_rap_pkg::ATTR_MAPPED || attr_type == stun_rap_pkg::ATTR_XOR) &&
                attr_len >= stun_rap_pkg::MIN_ADDR_LEN) begin
              res.address_kind = (attr_type == stun_rap_pkg::ATTR_XOR);
              res.address_family = capture[55:48];
              res.external_port = capture[47:32];
              res.external_ip = capture[31:0];
              if (res.address_kind) begin
                res.external_port = res.external_port ^ stun_rap_pkg::PORT_MASK;
                res.external_ip = res.external_ip ^ stun_rap_pkg::COOKIE;
              end
              expected_addrs.push_back(res);
              phase = stun_rap_pkg::PH_DONE;
            end else begin
              skip_value();
            end
          end
        end
        stun_rap_pkg::PH_PAD: begin
          pad_need = 16'd4 - {14'd0, attr_len[1:0]};
          sect_cnt = sect_cnt + 16'd1;
          if (sect_cnt >= pad_need) begin
            sect_cnt = '0;
            phase = stun_rap_pkg::PH_ATTR_HDR;
          end
        end
        default: begin
        end
      endcase
      if (last) begin
        clear_parse();
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
    endtask

    task check_address(stun_rap_pkg::addr_result_t got);
      stun_rap_pkg::addr_result_t want;
      if (expected_addrs.size() == 0) begin
        report_mismatch($sformatf("address with none expected: kind %0d family %02h port %04h ip %08h",
                                  got.address_kind, got.address_family, got.external_port,
                                  got.external_ip));
        return;
      end
      want = expected_addrs.pop_front();
      checked++;
      if (want.address_kind) begin
        xor_seen++;
      end
      compare_field("address_kind", 32'(got.address_kind), 32'(want.address_kind));
      compare_field("address_family", 32'(got.address_family), 32'(want.address_family));
      compare_field("external_port", 32'(got.external_port), 32'(want.external_port));
      compare_field("external_ip", got.external_ip, want.external_ip);
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit allow_gaps;
  int unsigned stall_cycles = 0;
  int unsigned bytes_sent;
  int unsigned datagrams_sent;
  logic [7:0] dgram[$];
  address_scoreboard addr_sb = new();

  stun_rap_in_if in_ch();
  stun_rap_out_if out_ch();

  stun_response_address_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= !allow_gaps || ($urandom_range(0, 99) >= 33);
  end

  // Both monitors sample at the edge, before the nonblocking updates of that edge land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        addr_sb.note_byte(in_ch.data_byte, in_ch.end_of_datagram);
      end
      if (out_ch.valid && out_ch.ready) begin
        addr_sb.check_address({out_ch.address_kind, out_ch.address_family,
                               out_ch.external_port, out_ch.external_ip});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("stun_response_address_parser_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic void add_fill(int unsigned n);
    repeat (n) dgram.push_back(8'($urandom));
  endfunction

  function automatic void add_header(logic [15:0] mtype);
    dgram.push_back(mtype[15:8]);
    dgram.push_back(mtype[7:0]);
    add_fill(stun_rap_pkg::HEADER_BYTES - 2);
  endfunction

  function automatic void add_attr_hdr(logic [15:0] atype, logic [15:0] alen);
    dgram.push_back(atype[15:8]);
    dgram.push_back(atype[7:0]);
    dgram.push_back(alen[15:8]);
    dgram.push_back(alen[7:0]);
  endfunction

  // Attribute with random value bytes and random padding up to a multiple of four.
  function automatic void add_attr(logic [15:0] atype, int unsigned alen);
    add_attr_hdr(atype, 16'(alen));
    add_fill(alen + ((4 - (alen % 4)) % 4));
  endfunction

  function automatic void trim_to(int unsigned n);
    while (dgram.size() > n) void'(dgram.pop_back());
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while (allow_gaps && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_datagram <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_datagram();
    foreach (dgram[i]) begin
      send_byte(dgram[i], i == dgram.size() - 1);
    end
    datagrams_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (addr_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // A lone byte that is also the last one.
    dgram.delete();
    dgram.push_back(stun_rap_pkg::TYPE_SUCCESS[15:8]);
    send_datagram();
    // Header only, no attributes.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    send_datagram();
    // Plain address of all zeros, followed by bytes that must be ignored.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr_hdr(stun_rap_pkg::ATTR_MAPPED, stun_rap_pkg::MIN_ADDR_LEN);
    repeat (8) dgram.push_back(8'h00);
    add_fill(8);
    send_datagram();
    // XOR address of all ones, whose last value byte also ends the datagram.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr_hdr(stun_rap_pkg::ATTR_XOR, stun_rap_pkg::MIN_ADDR_LEN);
    dgram.push_back(8'h00);
    repeat (7) dgram.push_back(8'hFF);
    send_datagram();
    // Wrong message type in the low byte, then in the high byte.
    dgram.delete();
    add_header(16'h0111);
    add_attr(stun_rap_pkg::ATTR_MAPPED, 8);
    send_datagram();
    dgram.delete();
    add_header(16'h0001);
    add_attr(stun_rap_pkg::ATTR_XOR, 8);
    send_datagram();
    // Datagrams cut short inside the header, an attribute header and a value.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    trim_to(10);
    send_datagram();
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr_hdr(stun_rap_pkg::ATTR_MAPPED, stun_rap_pkg::MIN_ADDR_LEN);
    trim_to(stun_rap_pkg::HEADER_BYTES + 2);
    send_datagram();
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr_hdr(stun_rap_pkg::ATTR_MAPPED, stun_rap_pkg::MIN_ADDR_LEN);
    add_fill(5);
    send_datagram();
    // Short address, empty address, odd unknown attribute, then a long XOR address.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr(stun_rap_pkg::ATTR_XOR, 4);
    add_attr(stun_rap_pkg::ATTR_MAPPED, 0);
    add_attr(16'h8022, 5);
    add_attr(stun_rap_pkg::ATTR_XOR, 12);
    add_fill(4);
    send_datagram();
    // Ends inside the padding of a one-byte attribute.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr_hdr(16'h0006, 16'd1);
    add_fill(2);
    send_datagram();
    // Long plain address wins over the XOR address after it.
    dgram.delete();
    add_header(stun_rap_pkg::TYPE_SUCCESS);
    add_attr(stun_rap_pkg::ATTR_MAPPED, 9);
    add_attr(stun_rap_pkg::ATTR_XOR, 8);
    send_datagram();
  endtask

  task automatic build_random_datagram();
    int unsigned pick;
    int unsigned n_other;
    int unsigned alen;
    pick = $urandom_range(0, 99);
    dgram.delete();
    if (pick < 8) begin
      // Noise, sometimes with a valid message type in front.
      add_fill($urandom_range(1, 40));
      if ($urandom_range(0, 1) == 1) begin
        dgram[0] = stun_rap_pkg::TYPE_SUCCESS[15:8];
        if (dgram.size() > 1) begin
          dgram[1] = stun_rap_pkg::TYPE_SUCCESS[7:0];
        end
      end
      return;
    end
    add_header((pick < 14) ? 16'($urandom) : stun_rap_pkg::TYPE_SUCCESS);
    n_other = $urandom_range(0, 3);
    repeat (n_other) add_attr(16'($urandom), $urandom_range(0, 11));
    if ($urandom_range(0, 9) == 0) begin
      add_attr(($urandom_range(0, 1) == 1) ? stun_rap_pkg::ATTR_XOR : stun_rap_pkg::ATTR_MAPPED,
               $urandom_range(0, 7));
    end
    if (pick < 20) begin
      // A wild attribute length that the datagram seldom fills.
      add_attr_hdr(16'($urandom), 16'($urandom));
      add_fill($urandom_range(0, 24));
      return;
    end
    alen = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16) : 8;
    add_attr(($urandom_range(0, 1) == 1) ? stun_rap_pkg::ATTR_XOR : stun_rap_pkg::ATTR_MAPPED,
             alen);
    add_fill($urandom_range(0, 8));
    if (pick >= 85) begin
      trim_to($urandom_range(1, dgram.size()));
    end
  endtask

  initial begin
    int unsigned idx;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_datagram <= 1'b0;
    rst_n <= 1'b0;
    allow_gaps = 1'b1;
    bytes_sent = 0;
    datagrams_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_for_results();

    idx = 0;
    while (bytes_sent < TARGET_BYTES && idx < 1000) begin
      // A run of datagrams with no random gaps on either side.
      allow_gaps = !(idx >= 10 && idx < 25);
      build_random_datagram();
      send_datagram();
      if (idx % 12 == 11) begin
        wait_for_results();
      end
      idx++;
    end
    allow_gaps = 1'b1;

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d datagrams (%0d bytes) with gaps, stalls and cut-short endings.",
             datagrams_sent, bytes_sent);
    $display("Checked %0d addresses, %0d of them XOR-decoded; %0d mismatches.",
             addr_sb.checked, addr_sb.xor_seen, addr_sb.errors);
    if (addr_sb.errors == 0 && addr_sb.pending() == 0) begin
      $display("stun_response_address_parser_unit_tb: done, clean");
    end else begin
      $display("stun_response_address_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/stun_rap_pkg.sv
src/stun_rap_if.sv
src/stun_rap_in_reg.sv
src/stun_rap_core.sv
src/stun_rap_out_reg.sv
src/stun_response_address_parser_unit.sv
tb/stun_response_address_parser_unit_tb.sv
